// ===== rtl/lzss_rgb_pkg.sv =====
// Shared constants, codes and structures of the LZSS RGB pixel decompressor.
`default_nettype none

package lzss_rgb_pkg;

	localparam int HIST_PIXELS = 4096;
	localparam int HIST_AW     = $clog2(HIST_PIXELS);
	localparam int CNT_W       = 25;
	localparam int PIXEL_W     = 24;
	localparam int CMDQ_DEPTH  = 4;
	localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
	localparam int RESQ_DEPTH  = 4;
	localparam int RESQ_AW     = $clog2(RESQ_DEPTH);

	// Register indexes on the configuration port.
	localparam logic REG_PIXEL_TOTAL   = 1'b0;
	localparam logic REG_SOURCE_LENGTH = 1'b1;

	// Command kinds passed from the parser to the pixel engine.
	localparam logic [1:0] KIND_LIT  = 2'd0;
	localparam logic [1:0] KIND_COPY = 2'd1;
	localparam logic [1:0] KIND_BAD  = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0] pixel_total;
		logic [CNT_W-1:0] source_length;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [PIXEL_W-1:0] pixel;
		logic [11:0]        dist_m1;
		logic [3:0]         len_m1;
		logic               done;
	} cmd_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               last;
		logic               bad;
		logic               done;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/lzss_rgb_cmdq.sv =====
// Short command queue between the stream parser and the pixel engine.
`default_nettype none

module lzss_rgb_cmdq (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  lzss_rgb_pkg::cmd_t  wr_data,
	output logic                full,
	output logic                rd_valid,
	input  wire                 rd_en,
	output lzss_rgb_pkg::cmd_t  rd_data
);

	lzss_rgb_pkg::cmd_t                  entry_q [lzss_rgb_pkg::CMDQ_DEPTH];
	logic [lzss_rgb_pkg::CMDQ_AW-1:0]    wptr_q;
	logic [lzss_rgb_pkg::CMDQ_AW-1:0]    rptr_q;
	logic [lzss_rgb_pkg::CMDQ_AW:0]      count_q;
	logic                                do_wr;
	logic                                do_rd;

	assign full     = (count_q == (lzss_rgb_pkg::CMDQ_AW+1)'(lzss_rgb_pkg::CMDQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lzss_rgb_front.sv =====
// Stream parser: takes code bytes, tracks flags and tokens, and issues pixel commands.
`default_nettype none

module lzss_rgb_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lzss_rgb_pkg::cfg_t  cfg,
	input  wire                 push,
	input  wire  [7:0]          code_byte,
	input  wire                 cmd_full,
	output logic                cmd_wr,
	output lzss_rgb_pkg::cmd_t  cmd_data
);

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_LIT1  = 2'd1;
	localparam logic [1:0] PH_LIT2  = 2'd2;
	localparam logic [1:0] PH_REF1  = 2'd3;

	logic [1:0]                       phase_q, phase_d;
	logic [7:0]                       flag_q, flag_d;
	logic [3:0]                       left_q, left_d;
	logic [7:0]                       held_lo_q, held_lo_d;
	logic [7:0]                       held_hi_q, held_hi_d;
	logic [lzss_rgb_pkg::CNT_W-1:0]   bytes_q, bytes_d;
	logic [lzss_rgb_pkg::CNT_W-1:0]   pix_q, pix_d;
	logic                             err_q, err_d;

	logic                             accept;
	logic [15:0]                      word;
	logic [12:0]                      ref_dist;
	logic [4:0]                       len;
	logic [lzss_rgb_pkg::CNT_W:0]     room;
	logic [4:0]                       eff;
	logic [lzss_rgb_pkg::CNT_W-1:0]   pix_lit;
	logic [lzss_rgb_pkg::CNT_W-1:0]   pix_copy;

	assign accept   = push && !cmd_full;
	assign word     = {code_byte, held_lo_q};
	assign ref_dist = {1'b0, word[15:4]} + 13'd1;
	assign len      = {1'b0, word[3:0]} + 5'd1;
	assign room     = {1'b0, cfg.pixel_total} - {1'b0, pix_q};
	assign pix_lit  = pix_q + 25'd1;
	assign pix_copy = pix_q + {20'd0, eff};

	// A negative room means the total was lowered below the count: no clipping then.
	always_comb begin
		if (!room[lzss_rgb_pkg::CNT_W] &&
		    (room[lzss_rgb_pkg::CNT_W-1:0] < {20'd0, len})) begin
			eff = room[4:0];
		end else begin
			eff = len;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		flag_d    = flag_q;
		left_d    = left_q;
		held_lo_d = held_lo_q;
		held_hi_d = held_hi_q;
		bytes_d   = bytes_q;
		pix_d     = pix_q;
		err_d     = err_q;
		cmd_wr    = 1'b0;
		cmd_data  = '0;
		if (accept) begin
			if (err_q) begin
				cmd_wr        = 1'b1;
				cmd_data.kind = lzss_rgb_pkg::KIND_BAD;
			end else if ((bytes_q < cfg.source_length) &&
			             !((phase_q == PH_START) && (pix_q >= cfg.pixel_total))) begin
				bytes_d = bytes_q + 25'd1;
				unique case (phase_q)
					PH_START: begin
						if (left_q == 4'd0) begin
							flag_d = code_byte;
							left_d = 4'd8;
						end else begin
							held_lo_d = code_byte;
							phase_d   = flag_q[7] ? PH_LIT1 : PH_REF1;
						end
					end
					PH_LIT1: begin
						held_hi_d = code_byte;
						phase_d   = PH_LIT2;
					end
					PH_LIT2: begin
						cmd_wr         = 1'b1;
						cmd_data.kind  = lzss_rgb_pkg::KIND_LIT;
						cmd_data.pixel = {code_byte, held_hi_q, held_lo_q};
						cmd_data.done  = (pix_lit == cfg.pixel_total);
						pix_d          = pix_lit;
						flag_d         = {flag_q[6:0], 1'b0};
						left_d         = left_q - 4'd1;
						phase_d        = PH_START;
					end
					PH_REF1: begin
						if ({12'd0, ref_dist} > pix_q) begin
							cmd_wr        = 1'b1;
							cmd_data.kind = lzss_rgb_pkg::KIND_BAD;
							err_d         = 1'b1;
						end else begin
							// A copy clipped to nothing still closes the token.
							cmd_wr           = (eff != 5'd0);
							cmd_data.kind    = lzss_rgb_pkg::KIND_COPY;
							cmd_data.dist_m1 = word[15:4];
							cmd_data.len_m1  = 4'(eff - 5'd1);
							cmd_data.done    = (pix_copy == cfg.pixel_total);
							pix_d            = pix_copy;
							flag_d           = {flag_q[6:0], 1'b0};
							left_d           = left_q - 4'd1;
							phase_d          = PH_START;
						end
					end
					default: phase_d = PH_START;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			flag_q    <= '0;
			left_q    <= '0;
			held_lo_q <= '0;
			held_hi_q <= '0;
			bytes_q   <= '0;
			pix_q     <= '0;
			err_q     <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			flag_q    <= flag_d;
			left_q    <= left_d;
			held_lo_q <= held_lo_d;
			held_hi_q <= held_hi_d;
			bytes_q   <= bytes_d;
			pix_q     <= pix_d;
			err_q     <= err_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lzss_rgb_back.sv =====
// Pixel engine: runs commands against the history memory and queues result beats.
`default_nettype none

module lzss_rgb_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cmd_valid,
	input  lzss_rgb_pkg::cmd_t     cmd_data,
	output logic                   cmd_pop,
	output logic                   res_empty,
	input  wire                    res_pop,
	output lzss_rgb_pkg::result_t  res_data
);

	logic [lzss_rgb_pkg::PIXEL_W-1:0]   hist_mem [lzss_rgb_pkg::HIST_PIXELS];

	logic [lzss_rgb_pkg::HIST_AW-1:0]   iwp_q;
	logic [lzss_rgb_pkg::HIST_AW-1:0]   wp_q;
	logic [3:0]                         idx_q;

	logic                               valid_s1;
	logic                               copy_s1;
	logic                               last_s1;
	logic                               bad_s1;
	logic                               done_s1;
	logic                               fwd_hit_s1;
	logic [lzss_rgb_pkg::PIXEL_W-1:0]   lit_s1;
	logic [lzss_rgb_pkg::PIXEL_W-1:0]   rd_px_s1;
	logic [lzss_rgb_pkg::PIXEL_W-1:0]   fwd_px_s1;

	lzss_rgb_pkg::result_t              rq_q [lzss_rgb_pkg::RESQ_DEPTH];
	logic [lzss_rgb_pkg::RESQ_AW-1:0]   rq_wptr_q;
	logic [lzss_rgb_pkg::RESQ_AW-1:0]   rq_rptr_q;
	logic [lzss_rgb_pkg::RESQ_AW:0]     rq_cnt_q;

	logic                               space;
	logic                               issue;
	logic                               is_copy;
	logic                               is_bad;
	logic                               last;
	logic [lzss_rgb_pkg::HIST_AW-1:0]   src_addr;
	logic [lzss_rgb_pkg::PIXEL_W-1:0]   px_s1;
	logic                               wr_s1;
	logic                               hit;
	logic                               rq_pop;
	lzss_rgb_pkg::result_t              rq_in;

	// Issue only when the result queue can hold this beat and the one in flight.
	assign space    = ((rq_cnt_q + {2'd0, valid_s1}) <
	                   (lzss_rgb_pkg::RESQ_AW+1)'(lzss_rgb_pkg::RESQ_DEPTH));
	assign issue    = cmd_valid && space;
	assign is_copy  = (cmd_data.kind == lzss_rgb_pkg::KIND_COPY);
	assign is_bad   = (cmd_data.kind == lzss_rgb_pkg::KIND_BAD);
	assign last     = !is_copy || (idx_q == cmd_data.len_m1);
	assign cmd_pop  = issue && last;
	assign src_addr = iwp_q - cmd_data.dist_m1 - 12'd1;

	assign px_s1 = copy_s1 ? (fwd_hit_s1 ? fwd_px_s1 : rd_px_s1) : lit_s1;
	assign wr_s1 = valid_s1 && !bad_s1;
	// A read of the entry written in the same cycle takes the pixel being written.
	assign hit   = wr_s1 && (src_addr == wp_q);

	assign rq_in.pixel = px_s1;
	assign rq_in.last  = last_s1;
	assign rq_in.bad   = bad_s1;
	assign rq_in.done  = done_s1;

	assign res_empty = (rq_cnt_q == '0);
	assign rq_pop    = res_pop && !res_empty;
	assign res_data  = rq_q[rq_rptr_q];

	always_ff @(posedge clk) begin
		if (issue && is_copy) begin
			rd_px_s1 <= hist_mem[src_addr];
		end
		if (wr_s1) begin
			hist_mem[wp_q] <= px_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			copy_s1    <= is_copy;
			lit_s1     <= cmd_data.pixel;
			last_s1    <= last;
			bad_s1     <= is_bad;
			done_s1    <= cmd_data.done && last;
			fwd_hit_s1 <= hit;
			fwd_px_s1  <= px_s1;
		end
		if (valid_s1) begin
			rq_q[rq_wptr_q] <= rq_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			iwp_q     <= '0;
			wp_q      <= '0;
			idx_q     <= '0;
			rq_wptr_q <= '0;
			rq_rptr_q <= '0;
			rq_cnt_q  <= '0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				idx_q <= last ? 4'd0 : idx_q + 4'd1;
				if (!is_bad) begin
					iwp_q <= iwp_q + 1'b1;
				end
			end
			if (wr_s1) begin
				wp_q <= wp_q + 1'b1;
			end
			if (valid_s1) begin
				rq_wptr_q <= rq_wptr_q + 1'b1;
			end
			if (rq_pop) begin
				rq_rptr_q <= rq_rptr_q + 1'b1;
			end
			case ({valid_s1, rq_pop})
				2'b10:   rq_cnt_q <= rq_cnt_q + 1'b1;
				2'b01:   rq_cnt_q <= rq_cnt_q - 1'b1;
				default: rq_cnt_q <= rq_cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lzss_rgb_pixel_decompressor_unit.sv =====
// Top level of the LZSS RGB pixel decompressor: configuration registers and the two halves.
//
//   channel   direction  handshake                 payload
//   config    in/out     psel penable pwrite pready paddr pwdata prdata
//   input     in         push / full               code_byte
//   result    out        empty / pop               channel_0..2 last_of_run malformed image_done
//
// A code byte is taken whenever the four-entry command queue has room.
// The pixel engine turns out one pixel per cycle while the result queue has room: a literal
// gives one pixel, a back reference one pixel per copied pixel (1 to 16).
// From the head of the command queue, a beat goes through the stage register, then the result queue.
// Reset clears control state at once and sets config registers to 1; history is not cleared.
// A stalled result side fills the result queue and then the command queue, then raises full.
`default_nettype none

module lzss_rgb_pixel_decompressor_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         push,
	output logic        full,
	input  wire  [7:0]  code_byte,
	output logic        empty,
	input  wire         pop,
	output logic [7:0]  channel_0,
	output logic [7:0]  channel_1,
	output logic [7:0]  channel_2,
	output logic        last_of_run,
	output logic        malformed,
	output logic        image_done
);

	lzss_rgb_pkg::cfg_t     cfg_q;
	lzss_rgb_pkg::cmd_t     fq_wr_data;
	lzss_rgb_pkg::cmd_t     fq_rd_data;
	lzss_rgb_pkg::result_t  res;
	logic                   fq_wr;
	logic                   fq_full;
	logic                   fq_valid;
	logic                   fq_pop;
	logic                   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_total   <= 25'd1;
			cfg_q.source_length <= 25'd1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				lzss_rgb_pkg::REG_PIXEL_TOTAL:   cfg_q.pixel_total   <= pwdata[24:0];
				lzss_rgb_pkg::REG_SOURCE_LENGTH: cfg_q.source_length <= pwdata[24:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			lzss_rgb_pkg::REG_PIXEL_TOTAL:   prdata = {7'd0, cfg_q.pixel_total};
			lzss_rgb_pkg::REG_SOURCE_LENGTH: prdata = {7'd0, cfg_q.source_length};
			default:                         prdata = '0;
		endcase
	end

	assign full = fq_full;

	lzss_rgb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.code_byte (code_byte),
		.cmd_full  (fq_full),
		.cmd_wr    (fq_wr),
		.cmd_data  (fq_wr_data)
	);

	lzss_rgb_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fq_wr),
		.wr_data  (fq_wr_data),
		.full     (fq_full),
		.rd_valid (fq_valid),
		.rd_en    (fq_pop),
		.rd_data  (fq_rd_data)
	);

	lzss_rgb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (fq_valid),
		.cmd_data  (fq_rd_data),
		.cmd_pop   (fq_pop),
		.res_empty (empty),
		.res_pop   (pop),
		.res_data  (res)
	);

	assign channel_0   = res.pixel[7:0];
	assign channel_1   = res.pixel[15:8];
	assign channel_2   = res.pixel[23:16];
	assign last_of_run = res.last;
	assign malformed   = res.bad;
	assign image_done  = res.done;

endmodule

`default_nettype wire

// ===== rtl/lzss_rgb_chk.sv =====
// Port-level checker for the LZSS RGB pixel decompressor, bound to the top level.
`default_nettype none

module lzss_rgb_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        empty,
	input wire        pop,
	input wire [7:0]  channel_0,
	input wire [7:0]  channel_1,
	input wire [7:0]  channel_2,
	input wire        last_of_run,
	input wire        malformed,
	input wire        image_done
);

	// A malformed beat carries no pixel and closes its run.
	a_bad_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && malformed) |->
			(channel_0 == 8'd0 && channel_1 == 8'd0 && channel_2 == 8'd0 &&
			 last_of_run && !image_done))
		else $error("malformed beat with pixel data or flags");

	// The pixel that completes the image is always the last of its run.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && image_done) |-> last_of_run)
		else $error("image_done without last_of_run");

	// Once a malformed beat is taken, every later beat is malformed too.
	a_bad_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && malformed) |=> (empty || malformed))
		else $error("good beat after a malformed beat");

	// A waiting beat holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=>
			(!empty && $stable(channel_0) && $stable(channel_1) && $stable(channel_2) &&
			 $stable(last_of_run) && $stable(malformed) && $stable(image_done)))
		else $error("result beat changed while stalled");

endmodule

bind lzss_rgb_pixel_decompressor_unit lzss_rgb_chk u_chk (.*);

`default_nettype wire

// ===== tb/lzss_rgb_pixel_decompressor_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LZSS RGB pixel decompressor unit.
module lzss_rgb_pixel_decompressor_unit_tb;

	localparam int unsigned MAX_TOTAL    = 32'd16777216;
	localparam int          SETTLE       = 12;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          LONG_HOLD    = 300;
	localparam int          RANDOM_ITEMS = 350;
	localparam int          QUIET_AFTER  = 280;
	localparam int unsigned WRITTEN_CAP  = 3700;

	typedef enum logic [1:0] {
		TOK_START,
		LIT_MID,
		LIT_LAST,
		REF_HIGH
	} token_phase_t;

	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic       last;
		logic       bad;
		logic       done;
	} pixel_beat_t;

	// Tracks the decoder state and holds the pixel beats still owed by the block.
	class lzss_pixel_tracker;
		pixel_beat_t                      pixels_due[$];
		logic [lzss_rgb_pkg::PIXEL_W-1:0] history[lzss_rgb_pkg::HIST_PIXELS];
		int unsigned                      written;
		int unsigned                      consumed;
		int unsigned                      pixel_total;
		int unsigned                      source_length;
		int unsigned                      flags_left;
		token_phase_t                     phase;
		logic [7:0]                       flags;
		logic [15:0]                      held;
		bit                               broken;
		int                               errors;
		int                               beats_checked;
		int                               images_done;
		int                               bad_beats;
		int                               bytes_taken;

		function new();
			written       = 0;
			consumed      = 0;
			pixel_total   = 1;
			source_length = 1;
			flags_left    = 0;
			phase         = TOK_START;
			flags         = 8'h00;
			held          = 16'h0000;
			broken        = 1'b0;
			errors        = 0;
			beats_checked = 0;
			images_done   = 0;
			bad_beats     = 0;
			bytes_taken   = 0;
		endfunction

		function void set_reg(logic idx, int unsigned value);
			if (idx == lzss_rgb_pkg::REG_PIXEL_TOTAL) begin
				pixel_total = value & 32'h01ff_ffff;
			end else begin
				source_length = value & 32'h01ff_ffff;
			end
		endfunction

		// Returns whether this mismatch is still among the ones worth printing.
		function bit count_mismatch();
			errors++;
			return errors <= 10;
		endfunction

		function void queue_pixel(logic [lzss_rgb_pkg::PIXEL_W-1:0] px, bit last, bit bad);
			pixel_beat_t beat;
			beat.c0   = px[7:0];
			beat.c1   = px[15:8];
			beat.c2   = px[23:16];
			beat.last = last;
			beat.bad  = bad;
			beat.done = !bad && (written == pixel_total);
			pixels_due.push_back(beat);
		endfunction

		function void store_pixel(logic [lzss_rgb_pkg::PIXEL_W-1:0] px);
			history[written % lzss_rgb_pkg::HIST_PIXELS] = px;
			written++;
		endfunction

		function void close_token();
			flags = flags << 1;
			if (flags_left > 0) flags_left--;
			phase = TOK_START;
		endfunction

		// Applies one accepted code byte; returns 1 when the byte had any effect.
		function bit take_code_byte(logic [7:0] b);
			logic [15:0]                      word;
			logic [lzss_rgb_pkg::PIXEL_W-1:0] px;
			int unsigned                      ref_dist;
			int unsigned                      count;
			int unsigned                      room;
			if (broken) begin
				queue_pixel('0, 1'b1, 1'b1);
				return 1'b1;
			end
			if (consumed >= source_length) return 1'b0;
			if (phase == TOK_START && written >= pixel_total) return 1'b0;
			consumed++;
			bytes_taken++;
			case (phase)
				TOK_START: begin
					if (flags_left == 0) begin
						flags      = b;
						flags_left = 8;
					end else begin
						held  = {8'h00, b};
						phase = flags[7] ? LIT_MID : REF_HIGH;
					end
				end
				LIT_MID: begin
					held[15:8] = b;
					phase      = LIT_LAST;
				end
				LIT_LAST: begin
					px = {b, held};
					store_pixel(px);
					queue_pixel(px, 1'b1, 1'b0);
					close_token();
				end
				default: begin
					word     = {b, held[7:0]};
					ref_dist = int'(word[15:4]) + 1;
					count    = int'(word[3:0]) + 1;
					room     = pixel_total - written;
					if (ref_dist > written) begin
						broken = 1'b1;
						queue_pixel('0, 1'b1, 1'b1);
						return 1'b1;
					end
					if (count > room) count = room;
					// Copying pixel by pixel lets an overlapping reference repeat itself.
					for (int i = 0; i < count; i++) begin
						px = history[(written - ref_dist) % lzss_rgb_pkg::HIST_PIXELS];
						store_pixel(px);
						queue_pixel(px, i + 1 == count, 1'b0);
					end
					close_token();
				end
			endcase
			return 1'b1;
		endfunction

		function void match_pixel(pixel_beat_t got);
			pixel_beat_t want;
			if (pixels_due.size() == 0) begin
				if (count_mismatch())
					$display("unexpected pixel beat: ch %h %h %h last %b bad %b done %b",
						got.c0, got.c1, got.c2, got.last, got.bad, got.done);
				return;
			end
			want = pixels_due.pop_front();
			beats_checked++;
			if (want.done) images_done++;
			if (want.bad) bad_beats++;
			if (got !== want) begin
				if (count_mismatch()) begin
					$display("pixel beat %0d: expected ch %h %h %h last %b bad %b done %b,",
						beats_checked, want.c0, want.c1, want.c2, want.last, want.bad,
						want.done);
					$display("    got ch %h %h %h last %b bad %b done %b",
						got.c0, got.c1, got.c2, got.last, got.bad, got.done);
				end
			end
		endfunction

		function void drain_check();
			if (pixels_due.size() != 0) begin
				$display("%0d pixel beats never arrived", pixels_due.size());
				errors += pixels_due.size();
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        push;
	logic        full;
	logic [7:0]  code_byte;
	logic        empty;
	logic        pop;
	logic [7:0]  channel_0;
	logic [7:0]  channel_1;
	logic [7:0]  channel_2;
	logic        last_of_run;
	logic        malformed;
	logic        image_done;

	lzss_pixel_tracker sb = new();
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit bad_mode = 1'b0;
	int hold_request = 0;
	int cycle_count = 0;

	lzss_rgb_pixel_decompressor_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.push        (push),
		.full        (full),
		.code_byte   (code_byte),
		.empty       (empty),
		.pop         (pop),
		.channel_0   (channel_0),
		.channel_1   (channel_1),
		.channel_2   (channel_2),
		.last_of_run (last_of_run),
		.malformed   (malformed),
		.image_done  (image_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("Verification failed");
		$finish;
	end

	initial begin : result_side
		int          stall;
		pixel_beat_t got;
		stall = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got = {channel_0, channel_1, channel_2, last_of_run, malformed, image_done};
				sb.match_pixel(got);
			end
			if (stall > 0) begin
				stall--;
			end else if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 4);
			end
			pop <= (stall == 0);
		end
	end

	task automatic send_byte(input logic [7:0] value, output bit took);
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		code_byte <= value;
		do @(posedge clk); while (full);
		took = sb.take_code_byte(value);
	endtask

	task automatic send_stream(input logic [7:0] stream[$]);
		bit took;
		foreach (stream[i]) send_byte(stream[i], took);
	endtask

	// Stops offering bytes, lets every owed beat arrive and gives the block time to settle.
	task automatic finish_beats();
		push <= 1'b0;
		while (sb.pixels_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int unsigned value);
		@(posedge clk);
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		pwrite  <= 1'b1;
		psel    <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[lzss_rgb_pkg::CNT_W-1:0] !== value[lzss_rgb_pkg::CNT_W-1:0]) begin
			if (sb.count_mismatch())
				$display("register %0d read back %h, expected %h", idx,
					prdata[lzss_rgb_pkg::CNT_W-1:0], value[lzss_rgb_pkg::CNT_W-1:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	// Picks the next code byte so that the stream stays well formed, or breaks it on purpose.
	function automatic logic [7:0] next_code_byte();
		logic [7:0]  b;
		int unsigned nib_max;
		int unsigned hi_max;
		int unsigned nib;
		int unsigned len;
		b = 8'($urandom);
		if (sb.phase == TOK_START) begin
			if (sb.flags_left == 0) begin
				if (bad_mode) b[7] = 1'b0;
				else if ($urandom_range(0, 3) != 0) b = b & 8'($urandom);
				if (sb.written == 0) b[7] = 1'b1;
			end else if (!sb.flags[7]) begin
				nib_max = (sb.written > 16) ? 15 : sb.written - 1;
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 15;
				b = {4'($urandom_range(0, nib_max)), 4'(len)};
			end
		end else if (sb.phase == REF_HIGH) begin
			nib = int'(sb.held[7:4]);
			hi_max = (sb.written - 1 - nib) >> 4;
			if (bad_mode) begin
				b = 8'($urandom_range(hi_max + 1, 255));
			end else begin
				if (hi_max > 255) hi_max = 255;
				b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, hi_max));
			end
		end
		return b;
	endfunction

	initial begin : stimulus
		logic [7:0]  dir[$];
		int          rand_items;
		int          budget;
		int          ignored;
		int          guard;
		int unsigned total;
		int unsigned src;
		bit          first;
		bit          took;
		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		push      <= 1'b0;
		code_byte <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest settings: only the flag byte is taken, then the source is used up.
		write_reg(lzss_rgb_pkg::REG_PIXEL_TOTAL, 1);
		write_reg(lzss_rgb_pkg::REG_SOURCE_LENGTH, 1);
		dir = '{8'hC0, 8'h12, 8'h34};
		send_stream(dir);
		finish_beats();

		// Extreme literals, then an overlapping copy clipped at the image end and ignored input.
		write_reg(lzss_rgb_pkg::REG_PIXEL_TOTAL, 6);
		write_reg(lzss_rgb_pkg::REG_SOURCE_LENGTH, MAX_TOTAL);
		dir = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h00, 8'h00, 8'h00};
		send_stream(dir);
		finish_beats();

		// A copy reaching back to the first pixel, a short copy, then the source ends inside a reference.
		write_reg(lzss_rgb_pkg::REG_PIXEL_TOTAL, MAX_TOTAL);
		write_reg(lzss_rgb_pkg::REG_SOURCE_LENGTH, sb.consumed + 5);
		dir = '{8'h50, 8'h00, 8'h12, 8'h00, 8'h0F, 8'hAB};
		send_stream(dir);
		finish_beats();

		// The interrupted reference resumes as a sixteen-pixel run.
		write_reg(lzss_rgb_pkg::REG_SOURCE_LENGTH, MAX_TOTAL);
		dir = '{8'h00};
		send_stream(dir);
		finish_beats();

		rand_items = 0;
		first = 1'b1;
		while (rand_items < RANDOM_ITEMS && sb.written < WRITTEN_CAP) begin
			if (rand_items >= QUIET_AFTER) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			if (first || $urandom_range(0, 4) == 0) total = MAX_TOTAL;
			else total = sb.written + $urandom_range(1, 300);
			if (!first && $urandom_range(0, 2) == 0) src = sb.consumed + $urandom_range(1, 60);
			else src = MAX_TOTAL;
			write_reg(lzss_rgb_pkg::REG_PIXEL_TOTAL, total);
			write_reg(lzss_rgb_pkg::REG_SOURCE_LENGTH, src);
			budget = first ? 80 : $urandom_range(20, 80);
			if (first) hold_request = LONG_HOLD;
			first = 1'b0;
			ignored = 0;
			while (budget > 0 && ignored < 2 && rand_items < RANDOM_ITEMS
					&& sb.written < WRITTEN_CAP) begin
				send_byte(next_code_byte(), took);
				if (took) begin
					rand_items++;
					budget--;
				end else begin
					ignored++;
				end
			end
			finish_beats();
		end

		// A reference before the first pixel breaks the stream for good.
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		write_reg(lzss_rgb_pkg::REG_PIXEL_TOTAL, MAX_TOTAL);
		write_reg(lzss_rgb_pkg::REG_SOURCE_LENGTH, MAX_TOTAL);
		bad_mode = 1'b1;
		guard = 0;
		while (!sb.broken && guard < 200) begin
			send_byte(next_code_byte(), took);
			guard++;
		end
		repeat (8) send_byte(8'($urandom), took);
		finish_beats();
		repeat (20) @(posedge clk);

		sb.drain_check();
		$display("Took %0d code bytes and checked %0d pixel beats, %0d of them ending an image.",
			sb.bytes_taken, sb.beats_checked, sb.images_done);
		$display("Stream errors gave %0d malformed beats; %0d mismatches in all.",
			sb.bad_beats, sb.errors);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
